// ===== design/bsil_pkg.sv =====
// Shared types and constants for the bounded sorted insertion list.
package bsil_pkg;

    // Payload widths fixed by the request format.
    localparam int ID_W = 32;
    localparam int TS_W = 48;

    // Default number of list cells.
    localparam int POOL_DEPTH_DEFAULT = 16;

    // Request action codes.
    typedef logic [1:0] t_action;
    localparam t_action ACT_CLEAR  = 2'd0;
    localparam t_action ACT_INSERT = 2'd1;
    localparam t_action ACT_TAKE   = 2'd2;
    localparam t_action ACT_NONE   = 2'd3;

    // What one cell shows its right-hand neighbor.
    typedef struct packed {
        logic            valid;
        logic            le;
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] ts;
    } t_link;

    // Command broadcast to every cell.
    typedef struct packed {
        logic            ins;
        logic            clr;
        logic [ID_W-1:0] id;
        logic [TS_W-1:0] ts;
    } t_cmd;

endpackage

// ===== design/bsil_if.sv =====
// Request and result channel interfaces of the bounded sorted insertion list.
interface bsil_in_if import bsil_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [1:0]      action;
    logic [ID_W-1:0] entry_id;
    logic [TS_W-1:0] entry_ts;

    modport source (output valid, action, entry_id, entry_ts, input ready);
    modport sink   (input valid, action, entry_id, entry_ts, output ready);
endinterface

interface bsil_out_if import bsil_pkg::*; #(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) ();
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    logic             valid;
    logic             ready;
    logic             inserted;
    logic             taken_valid;
    logic [ID_W-1:0]  taken_id;
    logic [TS_W-1:0]  taken_ts;
    logic [CNT_W-1:0] stored_count;

    modport source (output valid, inserted, taken_valid, taken_id, taken_ts, stored_count,
                    input ready);
    modport sink   (input valid, inserted, taken_valid, taken_id, taken_ts, stored_count,
                    output ready);
endinterface

// ===== design/bsil_cell.sv =====
// One compare-and-shift cell of the sorted list chain.
module bsil_cell import bsil_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_link i_prev,
    output t_link o_link
);

    logic            r_valid;
    logic [ID_W-1:0] r_id;
    logic [TS_W-1:0] r_ts;
    logic            w_le;
    logic            w_keep;
    logic            w_take_new;

    // The stored entry stays put when its timestamp is not above the new one.
    assign w_le       = (r_ts <= i_cmd.ts);
    assign w_keep     = r_valid && w_le;
    assign w_take_new = i_prev.valid && i_prev.le;

    // Occupancy: a cell fills when its left neighbor was already filled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clr) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins) begin
            r_valid <= i_prev.valid;
        end
    end

    // Entry data: either the new entry lands here or the left neighbor shifts in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !w_keep) begin
            if (w_take_new) begin
                r_id <= i_cmd.id;
                r_ts <= i_cmd.ts;
            end else begin
                r_id <= i_prev.id;
                r_ts <= i_prev.ts;
            end
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.le    = w_le;
    assign o_link.id    = r_id;
    assign o_link.ts    = r_ts;

endmodule

// ===== design/bounded_sorted_insert_list_unit.sv =====
// Top level of the bounded sorted insertion list.
//
// The block keeps up to POOL_DEPTH entries (id and timestamp) in ascending
// timestamp order, holding the smallest timestamps seen. Entries with equal
// timestamps keep their arrival order.
// Request channel i_req carries action, entry_id and entry_ts. Action clear
// empties the list and rewinds the read position, insert places an entry,
// take returns the entry at the read position and advances it.
// Result channel o_rsp carries one result per request: inserted,
// taken_valid, taken_id, taken_ts and stored_count after the request.
// For each request, the row of compare-and-shift cells updates all slots in
// the cycle it is accepted, and the result is in the output register on
// the next cycle. One request per cycle is sustained while the receiver
// takes results.
// When the receiver stalls, the result holds and i_req.ready drops until it
// is taken. After reset the list is empty and no result is pending.
module bounded_sorted_insert_list_unit import bsil_pkg::*; #(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bsil_in_if.sink           i_req,
    bsil_out_if.source        o_rsp
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

    t_link            w_out  [POOL_DEPTH];
    t_link            w_prev [POOL_DEPTH];
    t_cmd             w_cmd;
    logic             w_accept;
    logic             w_full;
    logic             w_refuse;
    logic             w_can_take;
    logic [IDX_W-1:0] w_rd_idx;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_rd_pos;
    logic [CNT_W-1:0] n_rd_pos;
    logic             r_valid;
    logic             r_inserted;
    logic             n_inserted;
    logic             r_taken_valid;
    logic             n_taken_valid;
    logic [ID_W-1:0]  r_taken_id;
    logic [ID_W-1:0]  n_taken_id;
    logic [TS_W-1:0]  r_taken_ts;
    logic [TS_W-1:0]  n_taken_ts;

    // A new request is taken whenever the result register is free or drains.
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // A full list refuses an entry that would land behind the last one.
    assign w_full     = (r_count == CNT_W'(POOL_DEPTH));
    assign w_refuse   = w_full && w_out[POOL_DEPTH-1].le;
    assign w_can_take = (r_rd_pos < r_count);
    assign w_rd_idx   = r_rd_pos[IDX_W-1:0];

    // Command broadcast to the cell row.
    assign w_cmd.ins = w_accept && (t_action'(i_req.action) == ACT_INSERT) && !w_refuse;
    assign w_cmd.clr = w_accept && (t_action'(i_req.action) == ACT_CLEAR);
    assign w_cmd.id  = i_req.entry_id;
    assign w_cmd.ts  = i_req.entry_ts;

    // Row of cells; the head of the row always offers the new entry.
    genvar g;
    generate
        for (g = 0; g < POOL_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign w_prev[g] = '{valid: 1'b1, le: 1'b1, id: '0, ts: '0};
            end else begin : g_body
                assign w_prev[g] = w_out[g-1];
            end
            bsil_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_prev  (w_prev[g]),
                .o_link  (w_out[g])
            );
        end
    endgenerate

    // Request decode: count, read position and result fields.
    always_comb begin
        n_count       = r_count;
        n_rd_pos      = r_rd_pos;
        n_inserted    = 1'b0;
        n_taken_valid = 1'b0;
        n_taken_id    = '0;
        n_taken_ts    = '0;
        unique case (t_action'(i_req.action))
            ACT_CLEAR: begin
                n_count  = '0;
                n_rd_pos = '0;
            end
            ACT_INSERT: begin
                if (!w_refuse) begin
                    n_inserted = 1'b1;
                    if (!w_full) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            ACT_TAKE: begin
                if (w_can_take) begin
                    n_taken_valid = 1'b1;
                    n_taken_id    = w_out[w_rd_idx].id;
                    n_taken_ts    = w_out[w_rd_idx].ts;
                    n_rd_pos      = r_rd_pos + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // List bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_pos <= '0;
        end else if (w_accept) begin
            r_count  <= n_count;
            r_rd_pos <= n_rd_pos;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_inserted    <= n_inserted;
            r_taken_valid <= n_taken_valid;
            r_taken_id    <= n_taken_id;
            r_taken_ts    <= n_taken_ts;
        end
    end

    assign o_rsp.valid        = r_valid;
    assign o_rsp.inserted     = r_inserted;
    assign o_rsp.taken_valid  = r_taken_valid;
    assign o_rsp.taken_id     = r_taken_id;
    assign o_rsp.taken_ts     = r_taken_ts;
    assign o_rsp.stored_count = r_count;

endmodule

// ===== design/bsil_checker.sv =====
// Port-level checks for the bounded sorted insertion list, bound to the top level.
module bsil_checker import bsil_pkg::*; #(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic [1:0]                        i_in_action,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_out_inserted,
    input logic                              i_out_taken_valid,
    input logic [$clog2(POOL_DEPTH + 1)-1:0] i_out_count
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    // An accepted request yields a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("no result after accepted request");

    // A clear leaves an empty list and reports nothing taken.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (t_action'(i_in_action) == ACT_CLEAR)
        |=> (i_out_count == '0) && !i_out_taken_valid && !i_out_inserted)
        else $error("clear did not empty the list");

    // A result never reports both an insert and a take.
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_inserted && i_out_taken_valid))
        else $error("result reports insert and take together");

    // The count never exceeds the list depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_count <= CNT_W'(POOL_DEPTH)))
        else $error("stored count above depth");

    // A stalled result stays presented.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

endmodule

bind bounded_sorted_insert_list_unit bsil_checker #(.POOL_DEPTH(POOL_DEPTH)) u_bsil_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_in_action       (i_req.action),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_out_inserted    (o_rsp.inserted),
    .i_out_taken_valid (o_rsp.taken_valid),
    .i_out_count       (o_rsp.stored_count)
);

// ===== sim/bsil_result_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard that predicts and checks every result of the bounded sorted insertion list.
module bsil_result_checker import bsil_pkg::*; #(
    parameter int POOL_DEPTH = POOL_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bsil_in_if   i_req_mon,
    bsil_out_if  i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int CNT_W = $clog2(POOL_DEPTH + 1);

    typedef struct packed {
        logic             inserted;
        logic             taken_valid;
        logic [ID_W-1:0]  taken_id;
        logic [TS_W-1:0]  taken_ts;
        logic [CNT_W-1:0] stored_count;
    } t_list_result;

    // Shadow copy of the list contents and its pointers.
    logic [ID_W-1:0] list_id [POOL_DEPTH];
    logic [TS_W-1:0] list_ts [POOL_DEPTH];
    int              list_count;
    int              read_pos;

    t_list_result    pending_results [$];
    t_list_result    got_result;
    t_list_result    want_result;
    int              mismatch_total;

    // Applies one request to the shadow list and returns the result it must produce.
    function automatic t_list_result apply_list_request(input t_action         act,
                                                        input logic [ID_W-1:0] id,
                                                        input logic [TS_W-1:0] ts);
        t_list_result res;
        int           place;
        int           last;
        res = '0;
        case (act)
            ACT_CLEAR: begin
                list_count = 0;
                read_pos   = 0;
            end
            ACT_INSERT: begin
                // A full list refuses a timestamp that is not below its last one.
                if (!(list_count >= POOL_DEPTH && list_ts[POOL_DEPTH-1] <= ts)) begin
                    // Equal timestamps go behind the stored ones, which keeps inserts stable.
                    place = 0;
                    while (place < list_count && list_ts[place] <= ts) begin
                        place++;
                    end
                    last = (list_count < POOL_DEPTH) ? list_count : POOL_DEPTH - 1;
                    for (int k = last; k > place; k--) begin
                        list_id[k] = list_id[k-1];
                        list_ts[k] = list_ts[k-1];
                    end
                    list_id[place] = id;
                    list_ts[place] = ts;
                    if (list_count < POOL_DEPTH) begin
                        list_count++;
                    end
                    res.inserted = 1'b1;
                end
            end
            ACT_TAKE: begin
                // An exhausted list returns nothing and keeps its read position.
                if (read_pos < list_count) begin
                    res.taken_valid = 1'b1;
                    res.taken_id    = list_id[read_pos];
                    res.taken_ts    = list_ts[read_pos];
                    read_pos++;
                end
            end
            default: begin
            end
        endcase
        res.stored_count = list_count[CNT_W-1:0];
        return res;
    endfunction

    // Compare each accepted result with the oldest prediction, then predict new requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_count     = 0;
            read_pos       = 0;
            mismatch_total = 0;
            pending_results.delete();
            for (int k = 0; k < POOL_DEPTH; k++) begin
                list_id[k] = '0;
                list_ts[k] = '0;
            end
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                got_result.inserted     = i_rsp_mon.inserted;
                got_result.taken_valid  = i_rsp_mon.taken_valid;
                got_result.taken_id     = i_rsp_mon.taken_id;
                got_result.taken_ts     = i_rsp_mon.taken_ts;
                got_result.stored_count = i_rsp_mon.stored_count;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual inserted %0b",
                             $time, got_result.inserted,
                             " taken_valid %0b taken_id %h taken_ts %h stored_count %0d",
                             got_result.taken_valid, got_result.taken_id,
                             got_result.taken_ts, got_result.stored_count);
                    mismatch_total++;
                end else begin
                    want_result = pending_results.pop_front();
                    if (got_result !== want_result) begin
                        $display("%0t: result mismatch (expected/actual): inserted %0b/%0b",
                                 $time, want_result.inserted, got_result.inserted,
                                 " taken_valid %0b/%0b taken_id %h/%h",
                                 want_result.taken_valid, got_result.taken_valid,
                                 want_result.taken_id, got_result.taken_id,
                                 " taken_ts %h/%h stored_count %0d/%0d",
                                 want_result.taken_ts, got_result.taken_ts,
                                 want_result.stored_count, got_result.stored_count);
                        mismatch_total++;
                    end
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                pending_results.push_back(apply_list_request(i_req_mon.action,
                                                             i_req_mon.entry_id,
                                                             i_req_mon.entry_ts));
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
module tb;
    import bsil_pkg::*;

    localparam int POOL_DEPTH   = POOL_DEPTH_DEFAULT;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_ITEMS   = 40;
    localparam int TAIL_CYCLES  = 20;
    localparam int LIMIT_CYCLES = 200000;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    int              fail_count;
    int              pending_count;
    int              cycle_count = 0;

    // Sender pacing state.
    int              burst_left   = 0;
    bit              tx_high      = 1'b0;
    bit              no_gaps      = 1'b0;
    int              work_items   = 0;
    logic [TS_W-1:0] ts_base      = '0;

    // Handshake between the stimulus and the receiver for the long hold-off.
    bit              hold_off_req = 1'b0;
    bit              hold_active  = 1'b0;

    bsil_in_if                                req_if ();
    bsil_out_if #(.POOL_DEPTH(POOL_DEPTH))    rsp_if ();

    bounded_sorted_insert_list_unit #(.POOL_DEPTH(POOL_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    bsil_result_checker #(.POOL_DEPTH(POOL_DEPTH)) u_result_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_if),
        .i_rsp_mon    (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Clock and cycle count.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up when the run takes far longer than the slowest correct run.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
        end
        $display("[bounded_sorted_insert_list_unit] ERROR");
        $finish;
    end

    function automatic logic [TS_W-1:0] random_ts();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[TS_W-1:0];
    endfunction

    // Timestamps mix ties, extremes and values clustered around a per-session base.
    function automatic logic [TS_W-1:0] pick_ts();
        case ($urandom_range(0, 5))
            0:       return TS_W'($urandom_range(0, 7));
            1:       return random_ts();
            2:       return {TS_W{1'b1}} - TS_W'($urandom_range(0, 3));
            3:       return '0;
            default: return ts_base + TS_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Offers one request and waits for it to be accepted; idles between bursts.
    task automatic send_request(input t_action         act,
                                input logic [ID_W-1:0] id,
                                input logic [TS_W-1:0] ts);
        int gap;
        req_if.valid    <= 1'b1;
        req_if.action   <= act;
        req_if.entry_id <= id;
        req_if.entry_ts <= ts;
        tx_high = 1'b1;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        if (act != ACT_NONE) begin
            work_items++;
        end
        if (burst_left > 0) begin
            burst_left--;
        end else if (!no_gaps) begin
            gap = $urandom_range(1, 8);
            req_if.valid    <= 1'b0;
            req_if.action   <= t_action'($urandom_range(0, 3));
            req_if.entry_id <= $urandom();
            req_if.entry_ts <= random_ts();
            tx_high = 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // A well-formed session: optional clear, inserts with some takes in between, then takes.
    task automatic run_list_session();
        int n_ins;
        int n_take;
        ts_base = random_ts();
        if ($urandom_range(0, 4) != 0) begin
            send_request(ACT_CLEAR, $urandom(), random_ts());
        end
        n_ins = ($urandom_range(0, 2) == 0) ? $urandom_range(17, 28) : $urandom_range(1, 16);
        repeat (n_ins) begin
            send_request(ACT_INSERT, pick_id(), pick_ts());
            if ($urandom_range(0, 4) == 0) begin
                send_request(ACT_TAKE, $urandom(), random_ts());
            end
        end
        n_take = $urandom_range(0, 20);
        repeat (n_take) begin
            send_request(ACT_TAKE, $urandom(), random_ts());
        end
    endtask

    // Random actions with random payload.
    task automatic run_noise();
        repeat ($urandom_range(1, 6)) begin
            send_request(t_action'($urandom_range(0, 3)), $urandom(), random_ts());
        end
    endtask

    // Receiver: segments of different stall patterns, and one long hold-off on request.
    initial begin
        int mode;
        int seg_len;
        int period;
        int phase;
        rsp_if.ready <= 1'b0;
        forever begin
            if (hold_off_req) begin
                @(posedge i_clk);
                rsp_if.ready <= 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active  = 1'b0;
                hold_off_req = 1'b0;
            end else begin
                mode    = $urandom_range(0, 3);
                seg_len = $urandom_range(16, 96);
                period  = $urandom_range(2, 5);
                phase   = 0;
                repeat (seg_len) begin
                    @(posedge i_clk);
                    case (mode)
                        0:       rsp_if.ready <= 1'b1;
                        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                        2:       rsp_if.ready <= (phase % period) != 0;
                        default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    phase++;
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int  start_items;
        bit  hold_done;
        hold_done = 1'b0;
        req_if.valid    <= 1'b0;
        req_if.action   <= ACT_NONE;
        req_if.entry_id <= '0;
        req_if.entry_ts <= '0;
        i_rst_n         <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, unused action, field extremes, ties, insert while reading.
        send_request(ACT_TAKE,   32'h0000_0001, '0);
        send_request(ACT_NONE,   '1, '1);
        send_request(ACT_INSERT, '1, '1);
        send_request(ACT_INSERT, '0, '0);
        send_request(ACT_INSERT, 32'hA5A5_5A5A, '1);
        send_request(ACT_INSERT, 32'h1234_5678, '0);
        send_request(ACT_TAKE,   '0, '0);
        send_request(ACT_TAKE,   '1, '1);
        send_request(ACT_INSERT, 32'hC0DE_0001, 48'd1);
        send_request(ACT_INSERT, 32'hC0DE_0002, '0);
        send_request(ACT_TAKE,   '0, '0);
        send_request(ACT_TAKE,   '0, '0);
        send_request(ACT_TAKE,   '0, '0);
        send_request(ACT_TAKE,   '0, '0);
        send_request(ACT_TAKE,   '0, '0);
        send_request(ACT_NONE,   32'h5555_AAAA, 48'hAAAA_5555_AAAA);
        send_request(ACT_CLEAR,  '1, '1);
        send_request(ACT_TAKE,   '0, '0);
        send_request(ACT_INSERT, 32'h0000_0042, 48'h8000_0000_0000);
        send_request(ACT_TAKE,   '0, '0);

        // Random part, with one long receiver hold-off while requests keep coming.
        start_items = work_items;
        while (work_items - start_items < RANDOM_ITEMS) begin
            if (!hold_done && work_items - start_items >= RANDOM_ITEMS / 3) begin
                hold_off_req = 1'b1;
                if (tx_high) begin
                    req_if.valid <= 1'b0;
                    tx_high = 1'b0;
                end
                do begin
                    @(posedge i_clk);
                end while (!hold_active);
                no_gaps    = 1'b1;
                burst_left = 0;
                ts_base    = random_ts();
                send_request(ACT_CLEAR, $urandom(), random_ts());
                repeat (HOLD_ITEMS) begin
                    send_request(($urandom_range(0, 3) == 0) ? ACT_TAKE : ACT_INSERT,
                                 pick_id(), pick_ts());
                end
                no_gaps   = 1'b0;
                hold_done = 1'b1;
            end else if ($urandom_range(0, 6) == 0) begin
                run_noise();
            end else begin
                run_list_session();
            end
        end
        if (tx_high) begin
            req_if.valid <= 1'b0;
        end

        // Drain outstanding results, then watch for stray ones.
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("[bounded_sorted_insert_list_unit] OK");
        end else begin
            $display("[bounded_sorted_insert_list_unit] ERROR");
        end
        $finish;
    end

endmodule
